@@ rtl/blstk_pkg.sv @@
// Package with the shared types, widths and codes of the bounded LIFO stack.
package blstk_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int DEPTH_DEF = 64;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_TRAVERSE = 3'd3,
        CMD_LENGTH   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [DATA_W-1:0] value;
    } item_t;

endpackage

@@ rtl/blstk_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module blstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/blstk_front.sv @@
// Front end: accepts commands, drops unknown codes and queues the rest for the back end.
module blstk_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [blstk_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
    input  logic [blstk_pkg::CMD_W-1:0]     s_tuser,  // [2:0] command
    output logic                            q_valid,
    output blstk_pkg::item_t                q_item,
    input  logic                            q_ready
);
    import blstk_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       known;
    logic       push;
    logic       pop;

    assign known    = s_tuser inside {[CMD_PUSH:CMD_LENGTH]};
    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready && known;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].cmd   <= cmd_t'(s_tuser);
            slot_reg[wr_ptr_reg].value <= s_tdata[DATA_W-1:0];
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 2'd2)
        else $error("Command queue fill exceeds its two slots.");

    a_fill_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("Queue fill did not rise after an enqueue.");

    a_fill_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> fill_reg == $past(fill_reg) - 2'd1)
        else $error("Queue fill did not fall after a dequeue.");

endmodule

@@ rtl/blstk_back.sv @@
// Back end: executes queued commands against the stack memory and drives the result register.
module blstk_back #(
    parameter int DEPTH = blstk_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  blstk_pkg::item_t                q_item,
    output logic                            q_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [blstk_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] data_out, [38:32] count_out
    output logic [blstk_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
    output logic                            m_tlast
);
    import blstk_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                trav_reg, trav_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;
    status_t             m_status_reg, m_status_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;
    logic                out_free;
    logic                take;
    logic                full;
    logic                empty;
    logic [CNT_W-1:0]    count_m1;
    logic                we;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
    logic [DATA_W-1:0]   rdata;

    assign out_free = !m_valid_reg || m_tready;
    assign q_ready  = (state_reg == S_IDLE) && out_free;
    assign take     = q_valid && q_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        trav_next     = trav_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        we            = 1'b0;
        re            = 1'b0;
        raddr         = count_m1[ADDR_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    m_data_next   = '0;
                    m_status_next = STATUS_OK;
                    m_count_next  = COUNT_W'(count_reg);
                    m_last_next   = 1'b1;
                    case (q_item.cmd)
                        CMD_PUSH: begin
                            m_valid_next = 1'b1;
                            if (full) begin
                                m_status_next = STATUS_OVERFLOW;
                            end else begin
                                we           = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                m_count_next = COUNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        CMD_POP, CMD_PEEK, CMD_TRAVERSE: begin
                            if (empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STATUS_EMPTY;
                            end else begin
                                re         = 1'b1;
                                idx_next   = count_m1[ADDR_W-1:0];
                                trav_next  = (q_item.cmd == CMD_TRAVERSE);
                                state_next = S_EMIT;
                                if (q_item.cmd == CMD_POP) begin
                                    count_next = count_m1;
                                end
                            end
                        end
                        CMD_LENGTH: begin
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = m_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rdata;
                    m_status_next = STATUS_OK;
                    m_count_next  = COUNT_W'(count_reg);
                    m_last_next   = !trav_reg || (idx_reg == '0);
                    if (trav_reg && (idx_reg != '0)) begin
                        re       = 1'b1;
                        raddr    = idx_reg - ADDR_W'(1);
                        idx_next = idx_reg - ADDR_W'(1);
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        trav_reg     <= trav_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    blstk_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(q_item.value),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, m_count_reg, m_data_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the stack depth.");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("Sequencer state is not one-hot.");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !q_ready)
        else $error("A command was dequeued while a read result was pending.");

endmodule

@@ rtl/bounded_lifo_stack.sv @@
// Top level of the bounded LIFO stack: command front end, execution back end.
//
// A stack of signed 32-bit words, DEPTH entries deep. Commands (push, pop, peek, traverse,
// length) arrive on the s_ stream with the code in s_tuser; unknown codes are dropped with
// no result. Results leave on the m_ stream, status in m_tuser and m_tlast on the final
// result of each command. A command is registered in a two-slot command queue before it
// reaches the back end. Push and length results are set straight from the command; pop
// and peek go through an emit state, because the stack memory has a registered read;
// traverse stays in that state and returns every held entry, top first. Pop, peek and
// traverse on an empty stack give the empty status without a memory read. The queue lets
// new commands be taken while a result is still waiting for its transfer.
module bounded_lifo_stack #(
    parameter int DEPTH = blstk_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [blstk_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
    input  logic [blstk_pkg::CMD_W-1:0]     s_tuser,  // [2:0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [blstk_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] data_out, [38:32] count_out
    output logic [blstk_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
    output logic                            m_tlast
);
    import blstk_pkg::*;

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    blstk_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    blstk_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
